FILE: rtl/core/sme_pkg.sv
// Package for the stack machine evaluator: opcodes, status codes, widths.
// No dependencies.
`default_nettype none
package sme_pkg;
    localparam int DATA_W = 32;
    localparam int CMD_W = 3;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W = 9;
    localparam int DEF_STACK_DEPTH = 256;

    localparam logic [CMD_W-1:0] OP_CONST = 3'd0;
    localparam logic [CMD_W-1:0] OP_ADD = 3'd1;
    localparam logic [CMD_W-1:0] OP_SUB = 3'd2;
    localparam logic [CMD_W-1:0] OP_MUL = 3'd3;
    localparam logic [CMD_W-1:0] OP_DIV = 3'd4;
    localparam logic [CMD_W-1:0] OP_NEG = 3'd5;
    localparam logic [CMD_W-1:0] OP_RET = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RET = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADOP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 3'd5;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

    // Divider handshake between the top level and the divide unit.
    typedef struct packed {
        logic start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic signed [DATA_W-1:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/sme_if.sv
// Valid/ready channel interface carrying the command or result payload.
// Depends on sme_pkg.
`default_nettype none
interface sme_in_if;
    import sme_pkg::*;
    logic valid;
    logic ready;
    logic [CMD_W-1:0] cmd;
    logic signed [DATA_W-1:0] operand_value;
    modport source (output valid, cmd, operand_value, input ready);
    modport sink (input valid, cmd, operand_value, output ready);
endinterface

interface sme_out_if;
    import sme_pkg::*;
    logic valid;
    logic ready;
    logic [STATUS_W-1:0] status;
    logic signed [DATA_W-1:0] result_value;
    logic [LEVEL_W-1:0] stack_level;
    modport source (output valid, status, result_value, stack_level, input ready);
    modport sink (input valid, status, result_value, stack_level, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/stack_machine_evaluator_unit.sv
// Top level of the stack machine evaluator: sequencer, operand stack RAM, divider.
// Depends on sme_pkg, sme_if, sme_ram and sme_div.
//
// Channel  Dir  Beat contents
// in       in   cmd, operand_value
// out      out  status, result_value, stack_level
//
// Each instruction reads up to two stack entries from the one-read-port RAM, one per
// cycle; a divide runs 48 one-bit divider steps before the quotient is presented. Reset
// empties the stack pointer at once; the RAM needs no clear. A new command is taken only
// when the result register is empty, so a stalled output holds the block.
`default_nettype none
module stack_machine_evaluator_unit #(
    parameter int STACK_DEPTH = sme_pkg::DEF_STACK_DEPTH
) (
    input wire logic clk,
    input wire logic rst_n,
    sme_in_if.sink   in,
    sme_out_if.source out
);
    import sme_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB = 3'd1;
    localparam logic [2:0] S_RDA = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_MUL = 3'd4;
    localparam logic [2:0] S_DIV = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic signed [DATA_W-1:0] a_reg, a_next, b_reg, b_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    logic ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;
    logic signed [DATA_W-1:0] oval_reg, oval_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;
    div_req_t dreq;
    div_rsp_t drsp;
    logic signed [DATA_W:0] sum;
    logic signed [2*DATA_W-16-1:0] pq;

    sme_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    sme_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        if (v > $signed({1'b0, SAT_MAX}))
            return SAT_MAX;
        else if (v < $signed({1'b1, SAT_MIN}))
            return SAT_MIN;
        else
            return v[DATA_W-1:0];
    endfunction

    assign in.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign out.valid = ovalid_reg;
    assign out.status = ost_reg;
    assign out.result_value = oval_reg;
    assign out.stack_level = LEVEL_W'(sp_reg);

    assign pq = prod_reg[2*DATA_W-1:16];

    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        cmd_next = cmd_reg;
        a_next = a_reg;
        b_next = b_reg;
        prod_next = prod_reg;
        ovalid_next = ovalid_reg;
        ost_next = ost_reg;
        oval_next = oval_reg;
        we = 1'b0;
        waddr = AW'(sp_reg - 1'b1);
        wdata = in.operand_value;
        raddr = AW'(sp_reg - 1'b1);
        dreq = '{start: 1'b0, num: a_reg, den: b_reg};
        sum = '0;
        if (out.valid && out.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in.valid && in.ready)
                begin
                    cmd_next = in.cmd;
                    ost_next = ST_OK;
                    oval_next = '0;
                    state_next = S_OUT;
                    unique case (in.cmd) inside
                        OP_CONST:
                        begin
                            if (sp_reg >= SPW'(STACK_DEPTH))
                                ost_next = ST_OVER;
                            else
                            begin
                                we = 1'b1;
                                waddr = AW'(sp_reg);
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        begin
                            if (sp_reg < SPW'(2))
                                ost_next = ST_UNDER;
                            else
                                state_next = S_RDB;
                        end
                        OP_NEG, OP_RET:
                        begin
                            if (sp_reg == '0)
                                ost_next = ST_UNDER;
                            else
                                state_next = S_RDA;
                        end
                        default: ost_next = ST_BADOP;
                    endcase
                end
            end
            S_RDB:
            begin
                // The top of stack is on the read port now; the next entry is addressed.
                b_next = rdata;
                raddr = AW'(sp_reg - 2'd2);
                state_next = S_RDA;
            end
            S_RDA:
            begin
                raddr = AW'(sp_reg - 2'd2);
                if (cmd_reg == OP_NEG || cmd_reg == OP_RET)
                    a_next = rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                if (cmd_reg == OP_NEG)
                begin
                    we = 1'b1;
                    wdata = sat33(-{a_reg[DATA_W-1], a_reg});
                end
                else if (cmd_reg == OP_RET)
                begin
                    sp_next = sp_reg - 1'b1;
                    ost_next = ST_RET;
                    oval_next = a_reg;
                end
                else
                begin
                    a_next = rdata;
                    if (cmd_reg == OP_MUL)
                    begin
                        prod_next = $signed(rdata) * b_reg;
                        state_next = S_MUL;
                    end
                    else if (cmd_reg == OP_DIV)
                    begin
                        if (b_reg == '0)
                        begin
                            we = 1'b1;
                            waddr = AW'(sp_reg - 2'd2);
                            wdata = rdata[DATA_W-1] ? SAT_MIN : SAT_MAX;
                            sp_next = sp_reg - 1'b1;
                            ost_next = ST_DIVZ;
                        end
                        else
                        begin
                            dreq = '{start: 1'b1, num: rdata, den: b_reg};
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        if (cmd_reg == OP_ADD)
                            sum = $signed({rdata[DATA_W-1], rdata}) + b_reg;
                        else
                            sum = $signed({rdata[DATA_W-1], rdata}) - b_reg;
                        we = 1'b1;
                        waddr = AW'(sp_reg - 2'd2);
                        wdata = sat33(sum);
                        sp_next = sp_reg - 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                // Arithmetic shift floors, which matches the required rounding.
                we = 1'b1;
                waddr = AW'(sp_reg - 2'd2);
                if (pq > $signed({{(DATA_W-16){1'b0}}, SAT_MAX}))
                    wdata = SAT_MAX;
                else if (pq < $signed({{(DATA_W-16){1'b1}}, SAT_MIN}))
                    wdata = SAT_MIN;
                else
                    wdata = pq[DATA_W-1:0];
                sp_next = sp_reg - 1'b1;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    we = 1'b1;
                    waddr = AW'(sp_reg - 2'd2);
                    wdata = drsp.quo;
                    sp_next = sp_reg - 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        a_reg <= a_next;
        b_reg <= b_next;
        prod_reg <= prod_next;
        ost_reg <= ost_next;
        oval_reg <= oval_next;
    end

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in.ready)
        else $error("command accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> out.valid && $stable(out.status)
            && $stable(out.result_value) && $stable(out.stack_level))
        else $error("result beat changed while stalled");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");
endmodule
`default_nettype wire

FILE: rtl/core/sme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/sme_div.sv
// Restoring Q16.16 divider, one quotient bit per cycle, with saturation.
// Depends on sme_pkg.
`default_nettype none
module sme_div (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sme_pkg::div_req_t req,
    output sme_pkg::div_rsp_t    rsp
);
    import sme_pkg::*;

    localparam int NUM_W = 48;
    localparam int CNT_W = 6;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [DATA_W:0]  rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic [DATA_W:0]  trial;
    logic [NUM_W:0]   qmag;
    logic signed [NUM_W+1:0] qs;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        trial = {rem_reg[DATA_W-1:0], num_reg[NUM_W-1]} - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(NUM_W);
            num_next = req.num[DATA_W-1] ? NUM_W'(-{{16{req.num[DATA_W-1]}}, req.num, 16'd0})
                                         : {req.num[DATA_W-1:0], 16'd0};
            den_next = req.den[DATA_W-1] ? -req.den : req.den;
            rem_next = '0;
            neg_next = req.num[DATA_W-1] ^ req.den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial;
                num_next = {num_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-1:0], num_reg[NUM_W-1]};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // The magnitude of a*2^16 fits 48 bits (2^47 at most).
    always_comb
    begin
        qmag = {1'b0, num_reg};
        qs = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        rsp.done = done_reg;
        if (qs > (NUM_W+2)'(SAT_MAX))
        begin
            rsp.quo = SAT_MAX;
        end
        else if (qs < $signed({{(NUM_W+2-DATA_W){1'b1}}, SAT_MIN}))
        begin
            rsp.quo = SAT_MIN;
        end
        else
        begin
            rsp.quo = qs[DATA_W-1:0];
        end
    end
endmodule
`default_nettype wire
